[hw/rtl/sha256_message_digest_macros.svh]
// Assertion macros for the SHA-256 message digest block.
`ifndef SHA256_MESSAGE_DIGEST_MACROS_SVH
`define SHA256_MESSAGE_DIGEST_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define SMD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define SMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/sha256md_pkg.sv]
// Shared types, constants and functions of the SHA-256 message digest block.
package sha256md_pkg;

    typedef logic [31:0]       t_word;
    typedef logic [7:0][31:0]  t_vars;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned WINDOW_WORDS = 16;
    localparam int unsigned ROUNDS = 64;
    localparam int unsigned DIGEST_WORDS = 8;

    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic [5:0] LAST_BYTE = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_OUT = 3'd7;
    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam t_vars HASH_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam t_word K_TABLE [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PAD  = 5'b00010,
        ST_COMP = 5'b00100,
        ST_FOLD = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    typedef struct packed {
        logic        wr;
        logic [5:0]  idx;
        logic [7:0]  data;
        logic        pad;
        logic        ovf;
        logic [63:0] len;
        logic        shift;
    } t_sched_ctl;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

[hw/rtl/sha256md_round.sv]
// One SHA-256 compression round, shared by all 64 rounds of a block.
module sha256md_round (
    input  sha256md_pkg::t_vars i_v,
    input  sha256md_pkg::t_word i_k,
    input  sha256md_pkg::t_word i_w,
    output sha256md_pkg::t_vars o_v
);
    import sha256md_pkg::*;

    t_word t1;
    t_word t2;
    t_word ch;
    t_word maj;

    always_comb begin
        ch  = (i_v[4] & i_v[5]) ^ (~i_v[4] & i_v[6]);
        maj = (i_v[0] & i_v[1]) ^ (i_v[0] & i_v[2]) ^ (i_v[1] & i_v[2]);
        t1  = i_v[7] + big_sigma1(i_v[4]) + ch + i_k + i_w;
        t2  = big_sigma0(i_v[0]) + maj;
        o_v[7] = i_v[6];
        o_v[6] = i_v[5];
        o_v[5] = i_v[4];
        o_v[4] = i_v[3] + t1;
        o_v[3] = i_v[2];
        o_v[2] = i_v[1];
        o_v[1] = i_v[0];
        o_v[0] = t1 + t2;
    end

endmodule

[hw/rtl/sha256md_sched.sv]
// Block buffer and message schedule window: byte fill, padding, word shift.
module sha256md_sched (
    input  logic                     i_clk,
    input  sha256md_pkg::t_sched_ctl i_ctl,
    output sha256md_pkg::t_word      o_w
);
    import sha256md_pkg::*;

    t_word r_w [WINDOW_WORDS];
    t_word n_w [WINDOW_WORDS];

    always_comb begin
        n_w = r_w;
        if (i_ctl.shift) begin
            for (int k = 0; k < WINDOW_WORDS - 1; k++) begin
                n_w[k] = r_w[k + 1];
            end
            n_w[WINDOW_WORDS - 1] = r_w[0] + small_sigma0(r_w[1]) + r_w[9]
                                  + small_sigma1(r_w[14]);
        end
        if (i_ctl.wr) begin
            n_w[i_ctl.idx[5:2]][{~i_ctl.idx[1:0], 3'b000} +: 8] = i_ctl.data;
        end
        if (i_ctl.pad) begin
            for (int k = 0; k < WINDOW_WORDS; k++) begin
                for (int b = 0; b < 4; b++) begin
                    if (i_ctl.ovf || 6'(4 * k + b) > i_ctl.idx) begin
                        n_w[k][31 - 8 * b -: 8] = 8'h00;
                    end else if (6'(4 * k + b) == i_ctl.idx) begin
                        n_w[k][31 - 8 * b -: 8] = PAD_MARK;
                    end
                end
            end
            if (i_ctl.ovf || i_ctl.idx < LEN_POS) begin
                n_w[WINDOW_WORDS - 2] = i_ctl.len[63:32];
                n_w[WINDOW_WORDS - 1] = i_ctl.len[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
    end

    assign o_w = r_w[0];

endmodule

[hw/rtl/sha256_message_digest.sv]
// SHA-256 message digest: byte stream in, eight digest words out.
//
// Input channel: one message byte per item in tdata, tuser high when the
// byte is present, tlast marking the end of the message (a byte in the same
// item is taken first). Output channel: eight 32-bit big-endian digest
// words, word 0 first, tlast on the eighth.
//
// The item that completes a 64-byte block is followed by a busy spell of 64
// rounds through the single round unit and one fold into the hash words. An
// end item adds one or two padding blocks, each a padding step, 64 rounds
// and a fold; then the eight words are offered. tready stays low while a
// block compresses and while the digest goes out.
//
// A stalled receiver holds the current digest word; nothing is dropped.
// After the eighth word is taken the hash words, length and fill count
// return to their initial values and the next message may start.
// Reset (synchronous, active low) does the same and clears the sequencer.
module sha256_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] msg_byte
    input  logic        i_s_axis_tuser,   // [0] byte_present
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] digest_word
    output logic        o_m_axis_tlast
);
    import sha256md_pkg::*;

    t_state      r_state, n_state;
    t_vars       r_hash, n_hash;
    t_vars       r_v, n_v;
    t_vars       v_round;
    logic [5:0]  r_cnt, n_cnt;
    logic [54:0] r_blk, n_blk;
    logic [5:0]  r_rnd, n_rnd;
    logic [2:0]  r_ocnt, n_ocnt;
    logic        r_fin, n_fin;
    logic        r_ovf, n_ovf;
    logic        r_tail, n_tail;
    t_sched_ctl  ctl;
    t_word       w_cur;
    logic        in_acc;
    logic        out_acc;

    sha256md_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .o_w   (w_cur)
    );

    sha256md_round u_round (
        .i_v (r_v),
        .i_k (K_TABLE[r_rnd]),
        .i_w (w_cur),
        .o_v (v_round)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = (r_state == ST_OUT);
    assign o_m_axis_tdata  = r_hash[r_ocnt];
    assign o_m_axis_tlast  = (r_ocnt == LAST_OUT);
    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;

    always_comb begin
        n_state = r_state;
        n_hash  = r_hash;
        n_v     = r_v;
        n_cnt   = r_cnt;
        n_blk   = r_blk;
        n_rnd   = r_rnd;
        n_ocnt  = r_ocnt;
        n_fin   = r_fin;
        n_ovf   = r_ovf;
        n_tail  = r_tail;
        ctl       = '0;
        ctl.idx   = r_cnt;
        ctl.data  = i_s_axis_tdata;
        ctl.ovf   = r_ovf;
        ctl.len   = {r_blk, r_cnt, 3'b000};
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_s_axis_tuser) begin
                        ctl.wr = 1'b1;
                        if (r_cnt == LAST_BYTE) begin
                            n_cnt   = '0;
                            n_blk   = r_blk + 55'd1;
                            n_fin   = i_s_axis_tlast;
                            n_v     = r_hash;
                            n_rnd   = '0;
                            n_state = ST_COMP;
                        end else begin
                            n_cnt = r_cnt + 6'd1;
                            if (i_s_axis_tlast) begin
                                n_fin   = 1'b1;
                                n_state = ST_PAD;
                            end
                        end
                    end else if (i_s_axis_tlast) begin
                        n_fin   = 1'b1;
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                ctl.pad = 1'b1;
                if (r_ovf || r_cnt < LEN_POS) begin
                    n_tail = 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end
                n_v     = r_hash;
                n_rnd   = '0;
                n_state = ST_COMP;
            end
            ST_COMP: begin
                ctl.shift = 1'b1;
                n_v       = v_round;
                n_rnd     = r_rnd + 6'd1;
                if (r_rnd == LAST_ROUND) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                for (int k = 0; k < DIGEST_WORDS; k++) begin
                    n_hash[k] = r_hash[k] + r_v[k];
                end
                priority if (r_tail) begin
                    n_ocnt  = '0;
                    n_state = ST_OUT;
                end else if (r_fin) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_acc) begin
                    n_ocnt = r_ocnt + 3'd1;
                    if (r_ocnt == LAST_OUT) begin
                        n_hash  = HASH_IV;
                        n_cnt   = '0;
                        n_blk   = '0;
                        n_fin   = 1'b0;
                        n_ovf   = 1'b0;
                        n_tail  = 1'b0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_hash  <= HASH_IV;
            r_cnt   <= '0;
            r_blk   <= '0;
            r_rnd   <= '0;
            r_ocnt  <= '0;
            r_fin   <= 1'b0;
            r_ovf   <= 1'b0;
            r_tail  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hash  <= n_hash;
            r_cnt   <= n_cnt;
            r_blk   <= n_blk;
            r_rnd   <= n_rnd;
            r_ocnt  <= n_ocnt;
            r_fin   <= n_fin;
            r_ovf   <= n_ovf;
            r_tail  <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
    end

`include "sha256_message_digest_macros.svh"

    `SMD_ASSERT_NEXT(a_end_busy, in_acc && i_s_axis_tlast, !o_s_axis_tready, "end item not taken up")
    `SMD_ASSERT_NEXT(a_round_done, (r_state == ST_COMP) && (r_rnd == LAST_ROUND), r_state == ST_FOLD, "compression overran")
    `SMD_ASSERT_NEXT(a_digest_clear, out_acc && o_m_axis_tlast, (r_hash == HASH_IV) && (r_cnt == '0) && (r_blk == '0), "state not cleared after digest")
    `SMD_ASSERT_SAME(a_ovf_final, r_ovf || r_tail, r_fin, "padding flags without end item")

endmodule

[tb/sha256_digest_checker.sv]
// Checker for the SHA-256 digest block: predicts each message digest and compares the words.
module sha256_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] msg_byte
    input  logic        i_s_tuser,    // [0] byte_present
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,    // [31:0] digest_word
    input  logic        i_m_tlast,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BLOCK_LEN = 64;
    localparam int unsigned LEN_AT = 56;
    localparam int unsigned DIGEST_LEN = 8;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] START_CHAIN [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct {
        logic [31:0] word;
        logic        last;
    } digest_word_t;

    logic [31:0]  chain [8];
    logic [7:0]   msg_block [64];
    int unsigned  fill;
    logic [63:0]  bit_count;
    digest_word_t digest_q [$];
    digest_word_t head;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_digest();
        chain = START_CHAIN;
        fill = 0;
        bit_count = '0;
    endfunction

    function automatic void absorb_block();
        logic [31:0] sched [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int t = 0; t < 16; t++)
            sched[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        for (int t = 16; t < 64; t++) begin
            s0 = ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3);
            s1 = ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10);
            sched[t] = sched[t-16] + s0 + sched[t-7] + s1;
        end
        v = chain;
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + sched[t];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int k = 0; k < 8; k++)
            chain[k] = chain[k] + v[k];
    endfunction

    function automatic void take_item(input logic [7:0] data, input logic present,
                                      input logic eom);
        int unsigned pos;
        logic [63:0] total;
        if (present) begin
            msg_block[fill] = data;
            fill++;
            if (fill == BLOCK_LEN) begin
                absorb_block();
                bit_count = bit_count + 64'd512;
                fill = 0;
            end
        end
        if (eom) begin
            total = bit_count + 64'(fill) * 64'd8;
            pos = fill;
            msg_block[pos] = PAD_BYTE;
            pos++;
            if (pos > LEN_AT) begin
                while (pos < BLOCK_LEN) begin
                    msg_block[pos] = 8'h00;
                    pos++;
                end
                absorb_block();
                pos = 0;
            end
            while (pos < LEN_AT) begin
                msg_block[pos] = 8'h00;
                pos++;
            end
            for (int k = 0; k < 8; k++)
                msg_block[LEN_AT + k] = total[63 - 8*k -: 8];
            absorb_block();
            for (int k = 0; k < DIGEST_LEN; k++)
                digest_q.push_back('{word: chain[k], last: (k == DIGEST_LEN - 1)});
            restart_digest();
        end
    endfunction

    initial begin
        o_errors = 0;
        o_pending = 0;
        restart_digest();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_digest();
            digest_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (digest_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected digest word: expected none, actual %h last %b",
                             $time, i_m_tdata, i_m_tlast);
                end else begin
                    head = digest_q.pop_front();
                    if (head.word !== i_m_tdata) begin
                        o_errors++;
                        $display("%0t: digest word mismatch: expected %h, actual %h",
                                 $time, head.word, i_m_tdata);
                    end
                    if (head.last !== i_m_tlast) begin
                        o_errors++;
                        $display("%0t: last flag mismatch: expected %b, actual %b",
                                 $time, head.last, i_m_tlast);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                take_item(i_s_tdata, i_s_tuser, i_s_tlast);
        end
        o_pending = digest_q.size();
    end

endmodule

[tb/tb_top.sv]
// Top of the SHA-256 digest testbench: clock, reset, message stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MSG_ITEM_BUDGET = 235;
    localparam int unsigned CALM_AFTER = 190;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam int unsigned TAIL_CYCLES = 150;
    localparam int unsigned EDGE_LENS [7] = '{55, 56, 57, 63, 64, 65, 120};

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'h00;   // [7:0] msg_byte
    logic        i_s_axis_tuser = 1'b0;    // [0] byte_present
    logic        i_s_axis_tlast = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;           // [31:0] digest_word
    logic        o_m_axis_tlast;

    int          errors;
    int          pending;
    int unsigned msg_items = 0;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;
    bit          held = 1'b0;

    sha256_message_digest i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    sha256_digest_checker digest_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .i_s_tlast  (i_s_axis_tlast),
        .i_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .i_m_tdata  (o_m_axis_tdata),
        .i_m_tlast  (o_m_axis_tlast),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    task automatic offer(input logic [7:0] data, input logic present, input logic eom);
        if (msg_items >= CALM_AFTER)
            calm = 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= data;
        i_s_axis_tuser <= present;
        i_s_axis_tlast <= eom;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
        if (present || eom)
            msg_items++;
    endtask

    task automatic send_message(input int unsigned len);
        bit tail_on_byte;
        tail_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0)
                offer(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            offer(8'($urandom_range(0, 255)), 1'b1, tail_on_byte && (k == len - 1));
        end
        if (!tail_on_byte)
            offer(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    initial begin : msg_source
        int unsigned msg_no;
        int unsigned len;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty message with stray data on the absent byte, then short messages and stray absent items
        offer(8'hff, 1'b0, 1'b1);
        offer(8'ha5, 1'b0, 1'b0);
        offer(8'h00, 1'b1, 1'b1);
        offer(8'hff, 1'b1, 1'b1);
        offer(8'h61, 1'b1, 1'b0);
        offer(8'h5a, 1'b0, 1'b0);
        offer(8'h62, 1'b1, 1'b0);
        offer(8'h63, 1'b1, 1'b0);
        offer(8'h00, 1'b0, 1'b1);
        offer(8'h80, 1'b1, 1'b0);
        offer(8'h7f, 1'b1, 1'b1);

        // hold until every digest is out
        i_s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);

        hold_req = 1'b1;
        msg_no = 0;
        while (msg_items < MSG_ITEM_BUDGET) begin
            if (msg_no == 0)
                len = 55;
            else if (msg_no == 1)
                len = 56;
            else if ($urandom_range(0, 5) == 0)
                len = EDGE_LENS[$urandom_range(0, 6)];
            else
                len = $urandom_range(0, 15);
            send_message(len);
            msg_no++;
        end

        i_s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial begin : digest_sink
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #3_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
